### design/ptl_pkg.sv
// Shared types and constants for the pump run timer with restart lockout.
package ptl_pkg;

  localparam int NUM_PUMPS = 2;
  localparam int PSEL_W    = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;

  localparam int OPC_W  = 2;
  localparam int PIDX_W = 2;
  localparam int TIME_W = 32;
  localparam int STAT_W = 3;
  localparam int MASK_W = 2;
  localparam int CFG_W  = 1;

  localparam logic [PIDX_W:0] NUM_PUMPS_C = (PIDX_W + 1)'(NUM_PUMPS);

  localparam logic [OPC_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OPC_W-1:0] OP_START = 2'd1;
  localparam logic [OPC_W-1:0] OP_STOP  = 2'd2;

  localparam logic [STAT_W-1:0] ST_STARTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_RUNNING = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOCKOUT = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STAT_W-1:0] ST_STOPPED = 3'd4;
  localparam logic [STAT_W-1:0] ST_TICK    = 3'd5;

  localparam logic [CFG_W-1:0] CFG_MIN_INTERVAL     = 1'd0;
  localparam logic [CFG_W-1:0] CFG_DEFAULT_DURATION = 1'd1;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [PIDX_W-1:0] pump_index;
    logic              use_default;
    logic [TIME_W-1:0] duration;
  } ptl_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PIDX_W-1:0] pump_echo;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] remaining;
    logic [MASK_W-1:0] pump_on_mask;
    logic [MASK_W-1:0] auto_stop_mask;
  } ptl_res_t;

endpackage

### design/ptl_in_stage.sv
// Input register that holds one request word until the execute logic takes it.
module ptl_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptl_pkg::ptl_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output ptl_pkg::ptl_item_t item
);

  logic               vld_r;
  logic               vld_nxt;
  ptl_pkg::ptl_item_t item_r;
  logic               accept;

  assign in_stall   = vld_r && !take;
  assign accept     = in_valid && !in_stall;
  assign vld_nxt    = accept ? 1'b1 : (take ? 1'b0 : vld_r);
  assign item_valid = vld_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

### design/ptl_exec.sv
// Pump state, configuration registers and the combinational request evaluation.
module ptl_exec (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ptl_pkg::CFG_W-1:0]    cfg_index,
  input  logic [ptl_pkg::TIME_W-1:0]   cfg_data,
  input  logic                         go,
  input  ptl_pkg::ptl_item_t           item,
  output ptl_pkg::ptl_res_t            res
);

  logic [ptl_pkg::TIME_W-1:0]    min_interval_r;
  logic [ptl_pkg::TIME_W-1:0]    default_duration_r;
  logic [ptl_pkg::TIME_W-1:0]    now_r;
  logic [ptl_pkg::TIME_W-1:0]    now_nxt;
  logic [ptl_pkg::NUM_PUMPS-1:0] run_r;
  logic [ptl_pkg::NUM_PUMPS-1:0] run_nxt;
  logic [ptl_pkg::TIME_W-1:0]    start_r  [ptl_pkg::NUM_PUMPS];
  logic [ptl_pkg::TIME_W-1:0]    start_nxt[ptl_pkg::NUM_PUMPS];
  logic [ptl_pkg::TIME_W-1:0]    last_r   [ptl_pkg::NUM_PUMPS];
  logic [ptl_pkg::TIME_W-1:0]    last_nxt [ptl_pkg::NUM_PUMPS];
  logic [ptl_pkg::TIME_W-1:0]    len_r    [ptl_pkg::NUM_PUMPS];
  logic [ptl_pkg::TIME_W-1:0]    len_nxt  [ptl_pkg::NUM_PUMPS];
  logic [ptl_pkg::NUM_PUMPS-1:0] expired;
  logic [ptl_pkg::PSEL_W-1:0]    sel;
  logic                          pvalid;
  logic [ptl_pkg::TIME_W-1:0]    run_el;
  logic [ptl_pkg::TIME_W-1:0]    run_left;
  logic [ptl_pkg::TIME_W-1:0]    since;
  logic [ptl_pkg::TIME_W-1:0]    new_len;
  logic [ptl_pkg::TIME_W-1:0]    tick_now;

  assign sel      = item.pump_index[ptl_pkg::PSEL_W-1:0];
  assign pvalid   = {1'b0, item.pump_index} < ptl_pkg::NUM_PUMPS_C;
  assign run_el   = now_r - start_r[sel];
  assign run_left = (run_el < len_r[sel]) ? (len_r[sel] - run_el) : '0;
  assign since    = now_r - last_r[sel];
  assign new_len  = item.use_default ? default_duration_r : item.duration;
  assign tick_now = now_r + 32'd1;

  // A pump expires once the advanced time has covered its run length.
  always_comb begin
    for (int i = 0; i < ptl_pkg::NUM_PUMPS; i++) begin
      expired[i] = run_r[i] && ((tick_now - start_r[i]) >= len_r[i]);
    end
  end

  always_comb begin
    now_nxt   = now_r;
    run_nxt   = run_r;
    start_nxt = start_r;
    last_nxt  = last_r;
    len_nxt   = len_r;
    res.status         = ptl_pkg::ST_TICK;
    res.pump_echo      = '0;
    res.elapsed        = '0;
    res.remaining      = '0;
    res.auto_stop_mask = '0;
    case (item.opcode)
      ptl_pkg::OP_TICK: begin
        now_nxt = tick_now;
        for (int i = 0; i < ptl_pkg::NUM_PUMPS; i++) begin
          if (expired[i]) begin
            run_nxt[i]  = 1'b0;
            last_nxt[i] = tick_now;
          end
        end
        res.auto_stop_mask = ptl_pkg::MASK_W'(expired);
      end
      ptl_pkg::OP_START: begin
        res.pump_echo = item.pump_index;
        if (!pvalid) begin
          res.status = ptl_pkg::ST_INVALID;
        end else if (run_r[sel]) begin
          res.status    = ptl_pkg::ST_RUNNING;
          res.elapsed   = run_el;
          res.remaining = run_left;
        end else if (since < min_interval_r) begin
          res.status    = ptl_pkg::ST_LOCKOUT;
          res.elapsed   = since;
          res.remaining = min_interval_r - since;
        end else begin
          res.status     = ptl_pkg::ST_STARTED;
          res.remaining  = new_len;
          run_nxt[sel]   = 1'b1;
          start_nxt[sel] = now_r;
          last_nxt[sel]  = now_r;
          len_nxt[sel]   = new_len;
        end
      end
      ptl_pkg::OP_STOP: begin
        res.pump_echo = item.pump_index;
        if (!pvalid) begin
          res.status = ptl_pkg::ST_INVALID;
        end else begin
          res.status    = ptl_pkg::ST_STOPPED;
          res.elapsed   = run_r[sel] ? run_el : '0;
          run_nxt[sel]  = 1'b0;
          last_nxt[sel] = now_r;
        end
      end
      default: begin
      end
    endcase
    res.pump_on_mask = ptl_pkg::MASK_W'(run_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r     <= '0;
      default_duration_r <= '0;
      now_r              <= '0;
      run_r              <= '0;
      for (int i = 0; i < ptl_pkg::NUM_PUMPS; i++) begin
        start_r[i] <= '0;
        last_r[i]  <= '0;
        len_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ptl_pkg::CFG_MIN_INTERVAL:     min_interval_r     <= cfg_data;
          ptl_pkg::CFG_DEFAULT_DURATION: default_duration_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (go) begin
        now_r   <= now_nxt;
        run_r   <= run_nxt;
        start_r <= start_nxt;
        last_r  <= last_nxt;
        len_r   <= len_nxt;
      end
    end
  end

endmodule

### design/ptl_out_stage.sv
// Result register that holds one result word until the receiver takes it.
module ptl_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ptl_pkg::ptl_res_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output ptl_pkg::ptl_res_t out_res
);

  logic              vld_r;
  logic              vld_nxt;
  ptl_pkg::ptl_res_t res_r;

  assign free      = !vld_r || !out_stall;
  assign vld_nxt   = load ? 1'b1 : (vld_r && out_stall);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### design/pump_run_timer_with_lockout.sv
// Top level of the pump run timer with restart lockout.
// The block takes one word per cycle while in_stall is low and returns exactly one
// result word per request, in order: the request is registered, evaluated
// combinationally against the pump state, and the result is registered. The
// pump state and the millisecond count update at the edge that loads the result,
// so the next request sees them at once. Configuration writes take effect at the
// next edge.
module pump_run_timer_with_lockout (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ptl_pkg::CFG_W-1:0]   cfg_index,
  input  logic [ptl_pkg::TIME_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ptl_pkg::OPC_W-1:0]   in_opcode,
  input  logic [ptl_pkg::PIDX_W-1:0]  in_pump_index,
  input  logic                        in_use_default,
  input  logic [ptl_pkg::TIME_W-1:0]  in_duration,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ptl_pkg::STAT_W-1:0]  out_status,
  output logic [ptl_pkg::PIDX_W-1:0]  out_pump_echo,
  output logic [ptl_pkg::TIME_W-1:0]  out_elapsed,
  output logic [ptl_pkg::TIME_W-1:0]  out_remaining,
  output logic [ptl_pkg::MASK_W-1:0]  out_pump_on_mask,
  output logic [ptl_pkg::MASK_W-1:0]  out_auto_stop_mask
);

  ptl_pkg::ptl_item_t in_item;
  ptl_pkg::ptl_item_t item;
  ptl_pkg::ptl_res_t  res;
  ptl_pkg::ptl_res_t  out_res;
  logic               item_valid;
  logic               out_free;
  logic               go;

  assign in_item.opcode      = in_opcode;
  assign in_item.pump_index  = in_pump_index;
  assign in_item.use_default = in_use_default;
  assign in_item.duration    = in_duration;

  assign go = item_valid && out_free;

  ptl_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (go),
    .item_valid (item_valid),
    .item       (item)
  );

  ptl_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .item      (item),
    .res       (res)
  );

  ptl_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_pump_echo      = out_res.pump_echo;
  assign out_elapsed        = out_res.elapsed;
  assign out_remaining      = out_res.remaining;
  assign out_pump_on_mask   = out_res.pump_on_mask;
  assign out_auto_stop_mask = out_res.auto_stop_mask;

endmodule

### design/ptl_checker.sv
// Port-level checks for the pump run timer and the bind that attaches them.
module ptl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ptl_pkg::STAT_W-1:0]  out_status,
  input logic [ptl_pkg::PIDX_W-1:0]  out_pump_echo,
  input logic [ptl_pkg::TIME_W-1:0]  out_elapsed,
  input logic [ptl_pkg::TIME_W-1:0]  out_remaining,
  input logic [ptl_pkg::MASK_W-1:0]  out_pump_on_mask,
  input logic [ptl_pkg::MASK_W-1:0]  out_auto_stop_mask
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_elapsed) && $stable(out_remaining) && $stable(out_pump_on_mask))
    else $error("Stalled result word changed.");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ptl_pkg::ST_TICK)
    else $error("Result status out of range.");

  a_auto_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ptl_pkg::ST_TICK) |-> out_auto_stop_mask == '0)
    else $error("Auto-stop reported on a non-tick word.");

  a_auto_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_auto_stop_mask & out_pump_on_mask) == '0)
    else $error("Auto-stopped pump still shown as on.");

  a_started_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ptl_pkg::ST_STARTED) |->
      ((out_pump_on_mask >> out_pump_echo) & 2'd1) == 2'd1 && out_elapsed == '0)
    else $error("Started pump not shown as on.");

endmodule

bind pump_run_timer_with_lockout ptl_checker u_ptl_checker (.*);

### bench/pump_run_timer_with_lockout_checker.sv
// Checker for the pump run timer: predicts each result word and compares it with the block.
`timescale 1ns / 1ps

module pump_run_timer_with_lockout_checker
  import ptl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [PIDX_W-1:0] in_pump_index,
  input  logic              in_use_default,
  input  logic [TIME_W-1:0] in_duration,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [STAT_W-1:0] out_status,
  input  logic [PIDX_W-1:0] out_pump_echo,
  input  logic [TIME_W-1:0] out_elapsed,
  input  logic [TIME_W-1:0] out_remaining,
  input  logic [MASK_W-1:0] out_pump_on_mask,
  input  logic [MASK_W-1:0] out_auto_stop_mask,
  output int                fail_count,
  output int                words_pending
);

  logic [TIME_W-1:0] lockout_ms;
  logic [TIME_W-1:0] fallback_run;
  logic [TIME_W-1:0] clock_ms;
  logic              pump_on    [NUM_PUMPS];
  logic [TIME_W-1:0] began_at   [NUM_PUMPS];
  logic [TIME_W-1:0] changed_at [NUM_PUMPS];
  logic [TIME_W-1:0] run_len    [NUM_PUMPS];

  ptl_res_t expected_words [$];

  task automatic clear_timer_state();
    lockout_ms   = '0;
    fallback_run = '0;
    clock_ms     = '0;
    for (int i = 0; i < NUM_PUMPS; i++) begin
      pump_on[i]    = 1'b0;
      began_at[i]   = '0;
      changed_at[i] = '0;
      run_len[i]    = '0;
    end
  endtask

  task automatic predict_timer_word(input ptl_item_t w, output ptl_res_t r);
    logic [TIME_W-1:0] since;
    int                p;
    r        = '0;
    r.status = ST_TICK;
    p        = int'(w.pump_index);
    case (w.opcode)
      OP_TICK: begin
        clock_ms = clock_ms + 1;
        for (int i = 0; i < NUM_PUMPS; i++) begin
          if (pump_on[i] && (clock_ms - began_at[i]) >= run_len[i]) begin
            pump_on[i]          = 1'b0;
            changed_at[i]       = clock_ms;
            r.auto_stop_mask[i] = 1'b1;
          end
        end
      end
      OP_START, OP_STOP: begin
        r.pump_echo = w.pump_index;
        if (p >= NUM_PUMPS) begin
          r.status = ST_INVALID;
        end else if (w.opcode == OP_START) begin
          if (pump_on[p]) begin
            r.elapsed   = clock_ms - began_at[p];
            r.remaining = (r.elapsed < run_len[p]) ? run_len[p] - r.elapsed : '0;
            r.status    = ST_RUNNING;
          end else begin
            since = clock_ms - changed_at[p];
            if (since < lockout_ms) begin
              r.elapsed   = since;
              r.remaining = lockout_ms - since;
              r.status    = ST_LOCKOUT;
            end else begin
              pump_on[p]    = 1'b1;
              began_at[p]   = clock_ms;
              changed_at[p] = clock_ms;
              run_len[p]    = w.use_default ? fallback_run : w.duration;
              r.remaining   = run_len[p];
              r.status      = ST_STARTED;
            end
          end
        end else begin
          if (pump_on[p]) begin
            r.elapsed = clock_ms - began_at[p];
          end
          pump_on[p]    = 1'b0;
          changed_at[p] = clock_ms;
          r.status      = ST_STOPPED;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NUM_PUMPS && i < MASK_W; i++) begin
      r.pump_on_mask[i] = pump_on[i];
    end
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ptl_item_t word_in;
    ptl_res_t  want;
    if (!rst_n) begin
      clear_timer_state();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_INTERVAL) begin
          lockout_ms = cfg_data;
        end else if (cfg_index == CFG_DEFAULT_DURATION) begin
          fallback_run = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        word_in.opcode      = in_opcode;
        word_in.pump_index  = in_pump_index;
        word_in.use_default = in_use_default;
        word_in.duration    = in_duration;
        predict_timer_word(word_in, want);
        expected_words.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("Result word arrived with no request outstanding.");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", TIME_W'(want.status), TIME_W'(out_status));
          check_field("pump_echo", TIME_W'(want.pump_echo), TIME_W'(out_pump_echo));
          check_field("elapsed", want.elapsed, out_elapsed);
          check_field("remaining", want.remaining, out_remaining);
          check_field("pump_on_mask", TIME_W'(want.pump_on_mask), TIME_W'(out_pump_on_mask));
          check_field("auto_stop_mask", TIME_W'(want.auto_stop_mask),
                      TIME_W'(out_auto_stop_mask));
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

### bench/pump_run_timer_with_lockout_test.sv
// Top of the pump run timer testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module pump_run_timer_with_lockout_test;
  import ptl_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASE_WORDS = 220;

  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_index;
  logic [TIME_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [OPC_W-1:0]  in_opcode;
  logic [PIDX_W-1:0] in_pump_index;
  logic              in_use_default;
  logic [TIME_W-1:0] in_duration;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [PIDX_W-1:0] out_pump_echo;
  logic [TIME_W-1:0] out_elapsed;
  logic [TIME_W-1:0] out_remaining;
  logic [MASK_W-1:0] out_pump_on_mask;
  logic [MASK_W-1:0] out_auto_stop_mask;

  int fail_count;
  int words_pending;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  pump_run_timer_with_lockout u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_pump_index      (in_pump_index),
    .in_use_default     (in_use_default),
    .in_duration        (in_duration),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_pump_echo      (out_pump_echo),
    .out_elapsed        (out_elapsed),
    .out_remaining      (out_remaining),
    .out_pump_on_mask   (out_pump_on_mask),
    .out_auto_stop_mask (out_auto_stop_mask)
  );

  pump_run_timer_with_lockout_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_pump_index      (in_pump_index),
    .in_use_default     (in_use_default),
    .in_duration        (in_duration),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_pump_echo      (out_pump_echo),
    .out_elapsed        (out_elapsed),
    .out_remaining      (out_remaining),
    .out_pump_on_mask   (out_pump_on_mask),
    .out_auto_stop_mask (out_auto_stop_mask),
    .fail_count         (fail_count),
    .words_pending      (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(200, 20);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      2: out_stall <= ($urandom_range(9) < 7);
      default: out_stall <= (stall_left % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("pump_run_timer_with_lockout_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_timer_config(input logic [TIME_W-1:0] min_gap,
                                    input logic [TIME_W-1:0] run_default);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_INTERVAL;
    cfg_data  <= min_gap;
    @(posedge clk);
    cfg_index <= CFG_DEFAULT_DURATION;
    cfg_data  <= run_default;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_word(input logic [OPC_W-1:0] op, input logic [PIDX_W-1:0] pump,
                           input logic use_def, input logic [TIME_W-1:0] run_ms);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(200, 80) : $urandom_range(40, 1);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_pump_index  <= pump;
    in_use_default <= use_def;
    in_duration    <= run_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic send_random_word();
    int                roll;
    logic [TIME_W-1:0] run_ms;
    roll = $urandom_range(99);
    if ($urandom_range(19) < 17) begin
      run_ms = $urandom_range(25);
    end else if ($urandom_range(1) == 0) begin
      run_ms = $urandom();
    end else begin
      run_ms = ($urandom_range(1) == 0) ? '0 : '1;
    end
    if (roll < 50) begin
      send_word(OP_TICK, PIDX_W'($urandom_range(3)), 1'($urandom_range(1)), $urandom());
    end else if (roll < 75) begin
      send_word(OP_START, PIDX_W'($urandom_range(NUM_PUMPS - 1)), ($urandom_range(3) == 0),
                run_ms);
    end else if (roll < 90) begin
      send_word(OP_STOP, PIDX_W'($urandom_range(NUM_PUMPS - 1)), 1'($urandom_range(1)),
                $urandom());
    end else if (roll < 95) begin
      send_word(($urandom_range(1) == 0) ? OP_START : OP_STOP,
                PIDX_W'($urandom_range(3, NUM_PUMPS)), 1'($urandom_range(1)), run_ms);
    end else begin
      send_word(OP_SPARE, PIDX_W'($urandom_range(3)), 1'($urandom_range(1)), $urandom());
    end
  endtask

  initial begin
    logic [TIME_W-1:0] gap_set [6];
    logic [TIME_W-1:0] run_set [6];
    gap_set = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd20, 32'd1, 32'd0};
    run_set = '{32'd0, 32'd7, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd12};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_opcode      = OP_TICK;
    in_pump_index  = '0;
    in_use_default = 1'b0;
    in_duration    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_timer_config(32'd3, 32'd2);

    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_START, 2'd0, 1'b0, 32'd5);
    send_word(OP_TICK, 2'd3, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_START, 2'd0, 1'b0, 32'd5);
    send_word(OP_START, 2'd0, 1'b0, 32'd9);
    send_word(OP_START, 2'd1, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_START, 2'd1, 1'b0, 32'd4);
    send_word(OP_STOP, 2'd0, 1'b0, 32'd0);
    send_word(OP_STOP, 2'd1, 1'b0, 32'd0);
    send_word(OP_START, 2'd2, 1'b0, 32'd8);
    send_word(OP_STOP, 2'd3, 1'b1, 32'd0);
    send_word(OP_START, 2'd3, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_SPARE, 2'd3, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_START, 2'd0, 1'b0, 32'd0);
    send_word(OP_START, 2'd1, 1'b0, 32'hFFFF_FFFF);
    send_word(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_word(OP_START, 2'd1, 1'b0, 32'd1);
    send_word(OP_STOP, 2'd1, 1'b0, 32'd0);
    send_word(OP_SPARE, 2'd0, 1'b0, 32'd0);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      write_timer_config(gap_set[ph], run_set[ph]);
      repeat (PHASE_WORDS) send_random_word();
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("pump_run_timer_with_lockout_test: PASS");
    end else begin
      $display("pump_run_timer_with_lockout_test: FAIL");
    end
    $finish;
  end

endmodule
